// File: hdl/mains_frequency_tracker_assert.svh
// ----------------------------------------------------------------------------
// mains frequency tracker assertion macros
// shorthand for clocked properties, disabled while reset is low
// ----------------------------------------------------------------------------
`ifndef MAINS_FREQUENCY_TRACKER_ASSERT_SVH
`define MAINS_FREQUENCY_TRACKER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define MFT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define MFT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/mft_pkg.sv
// ----------------------------------------------------------------------------
// mft_pkg
// shared types and constants of the mains frequency tracker
// ----------------------------------------------------------------------------
package mft_pkg;

    localparam int unsigned PERIOD_W    = 32;
    localparam int unsigned FREQ_OUT_W  = 30;
    localparam int unsigned COUNT_W     = 8;
    localparam int unsigned FRAC_BITS   = 10;
    localparam int unsigned PROD_A_W    = 36;
    localparam int unsigned PROD_B_W    = 27;
    localparam int unsigned SPAN_W      = 11;
    localparam int unsigned FREQ_BITS   = 26;

    // serial divider geometry
    localparam int unsigned DIV_W       = 32;
    localparam int unsigned DIV_LOW_W   = 42;
    localparam int unsigned STEP_W      = 6;

    // reciprocals for the constant divisions, exact over the operand ranges
    localparam int unsigned RECIP_W          = 28;
    localparam int unsigned RECIP_1000_SHIFT = 37;
    localparam int unsigned RECIP_10_SHIFT   = 35;

    localparam logic [PERIOD_W-1:0]  PERIOD_RESET   = 32'd1315790;
    localparam logic [FRAC_BITS-1:0] FRAC_SCALE     = 10'd1000;
    // ceil(2^37 / 1000), operand below 2^27
    localparam logic [RECIP_W-1:0]   RECIP_1000     = 28'd137438954;
    // ceil(2^35 / 10), operand below 2^32
    localparam logic [PERIOD_W-1:0]  RECIP_10       = 32'hCCCC_CCCD;
    // 1e9 / 16, exact
    localparam logic [FREQ_BITS-1:0] FREQ_NUM_DIV16 = 26'd62500000;

    typedef struct packed {
        logic                   start;
        logic [DIV_W-1:0]       rem;
        logic [DIV_LOW_W-1:0]   low;
        logic [DIV_W-1:0]       den;
        logic [STEP_W-1:0]      steps;
    } t_div_req;

    typedef struct packed {
        logic                   rising_edge;
        logic [PERIOD_W-1:0]    period_in_use;
        logic                   period_updated;
        logic [PERIOD_W-1:0]    new_period;
        logic [FREQ_OUT_W-1:0]  freq_times10;
        logic                   freq_invalid;
    } t_result;

endpackage

// File: hdl/mains_frequency_tracker.sv
// ----------------------------------------------------------------------------
// mains_frequency_tracker
// line frequency tracking from rising zero crossings of voltage samples
// ----------------------------------------------------------------------------
// Samples enter through a queue-style port: a transfer happens on a rising
// edge with push high and full low. Every sample yields exactly one result,
// read through empty/pop: the oldest result is on the o_ ports while empty is
// low and leaves on a rising edge with pop high.
// i_cfg_we with i_cfg_wdata loads the stored sample period (ns); write it
// only while no sample is in flight.
// The front detects crossings and can take one sample per cycle into a
// two-entry queue while that queue is not full; the back handles one item
// at a time. Constant divisions use reciprocal multiplies; a shared divider
// retires one quotient bit per cycle for the crossing fraction and for 1e9/x:
//   ordinary sample           no divide
//   crossing, no update       adds the 10-bit fraction divide
//   crossing with update      also adds the 26-bit 1e9/x divide,
//                             skipped when the new period is below 10
// Reset clears the crossing history and loads the period with 1315790 ns;
// both queues come up empty. When the receiver stalls, a two-entry result
// queue fills, then the back waits and full rises once the front queue fills.
// ----------------------------------------------------------------------------
module mains_frequency_tracker #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] i_sample,
    input  logic               i_cfg_we,
    input  logic [31:0]        i_cfg_wdata,
    output logic               empty,
    input  logic               pop,
    output logic               o_rising_edge,
    output logic [31:0]        o_period_in_use,
    output logic               o_period_updated,
    output logic [31:0]        o_new_period,
    output logic [29:0]        o_freq_times10,
    output logic               o_freq_invalid
);

    import mft_pkg::*;

    localparam int ITEM_W = 2 * SAMPLE_WIDTH;
    localparam int RES_W  = $bits(t_result);

    logic              w_mid_push;
    logic              w_mid_full;
    logic              w_mid_pop;
    logic              w_mid_empty;
    logic [ITEM_W-1:0] w_mid_in;
    logic [ITEM_W-1:0] w_mid_out;
    logic              w_res_push;
    logic              w_res_full;
    t_result           w_res_in;
    logic [RES_W-1:0]  w_res_out;
    t_result           w_res;

    mft_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_sample (i_sample),
        .o_full   (full),
        .i_q_full (w_mid_full),
        .o_q_push (w_mid_push),
        .o_q_item (w_mid_in)
    );

    mft_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (2)
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_mid_push),
        .i_data  (w_mid_in),
        .o_full  (w_mid_full),
        .i_pop   (w_mid_pop),
        .o_data  (w_mid_out),
        .o_empty (w_mid_empty)
    );

    mft_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_mid_item  (w_mid_out),
        .i_mid_empty (w_mid_empty),
        .o_mid_pop   (w_mid_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res_data  (w_res_in)
    );

    mft_queue #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_out),
        .o_empty (empty)
    );

    assign w_res            = t_result'(w_res_out);
    assign o_rising_edge    = w_res.rising_edge;
    assign o_period_in_use  = w_res.period_in_use;
    assign o_period_updated = w_res.period_updated;
    assign o_new_period     = w_res.new_period;
    assign o_freq_times10   = w_res.freq_times10;
    assign o_freq_invalid   = w_res.freq_invalid;

endmodule

// File: hdl/mft_queue.sv
// ----------------------------------------------------------------------------
// mft_queue
// small synchronous fifo with full and empty flags
// ----------------------------------------------------------------------------
module mft_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push & ~o_full;
    assign w_rd    = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: hdl/mft_div.sv
// ----------------------------------------------------------------------------
// mft_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mft_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  mft_pkg::t_div_req       i_req,
    output logic                    o_done,
    output logic [mft_pkg::DIV_W-1:0] o_quot
);

    import mft_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [STEP_W-1:0]    r_cnt;
    logic [DIV_W-1:0]     r_rem;
    logic [DIV_LOW_W-1:0] r_low;
    logic [DIV_W-1:0]     r_den;
    logic [DIV_W-1:0]     r_quot;
    logic [DIV_W:0]       w_trial;
    logic [DIV_W:0]       w_diff;
    logic                 w_ge;

    // partial remainder stays below the divisor, so the trial fits one extra bit
    assign w_trial = {r_rem, r_low[DIV_LOW_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    assign o_done = r_done;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= ~i_req.start & r_busy & (r_cnt == STEP_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.rem;
            r_low  <= i_req.low;
            r_den  <= i_req.den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
            r_low  <= {r_low[DIV_LOW_W-2:0], 1'b0};
            r_quot <= {r_quot[DIV_W-2:0], w_ge};
        end
    end

endmodule

// File: hdl/mft_front.sv
// ----------------------------------------------------------------------------
// mft_front
// sample intake and rising zero crossing detection
// ----------------------------------------------------------------------------
module mft_front #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic signed [31:0]        i_sample,
    output logic                      o_full,
    input  logic                      i_q_full,
    output logic                      o_q_push,
    output logic [2*SAMPLE_WIDTH-1:0] o_q_item
);

    logic                    r_have_prev;
    logic [SAMPLE_WIDTH-1:0] r_prev;
    logic [SAMPLE_WIDTH-1:0] w_s;
    logic [SAMPLE_WIDTH-1:0] w_diff;
    logic                    w_edge;
    logic                    w_accept;

    assign w_s      = i_sample[SAMPLE_WIDTH-1:0];
    assign w_accept = i_push & ~i_q_full;
    // previous negative, this one zero or positive
    assign w_edge   = r_have_prev & r_prev[SAMPLE_WIDTH-1] & ~w_s[SAMPLE_WIDTH-1];
    // on a crossing this is the true unsigned distance between the samples
    assign w_diff   = w_s - r_prev;

    assign o_full   = i_q_full;
    assign o_q_push = w_accept;
    assign o_q_item = {w_edge, w_s[SAMPLE_WIDTH-2:0], w_diff};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
        end else if (w_accept) begin
            r_have_prev <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_prev <= w_s;
        end
    end

endmodule

// File: hdl/mft_back.sv
// ----------------------------------------------------------------------------
// mft_back
// cycle counting, crossing interpolation, period and frequency update
// ----------------------------------------------------------------------------
module mft_back #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [31:0]                 i_cfg_wdata,
    input  logic [2*SAMPLE_WIDTH-1:0]   i_mid_item,
    input  logic                        i_mid_empty,
    output logic                        o_mid_pop,
    input  logic                        i_res_full,
    output logic                        o_res_push,
    output mft_pkg::t_result            o_res_data
);

    import mft_pkg::*;

    localparam int ITEM_W       = 2 * SAMPLE_WIDTH;
    localparam int SCALE_PROD_W = PROD_B_W + RECIP_W;
    localparam int TENTH_PROD_W = 2 * PERIOD_W;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_FRAC   = 8'b0000_0010,
        S_DECIDE = 8'b0000_0100,
        S_MUL    = 8'b0000_1000,
        S_SCALE  = 8'b0001_0000,
        S_TEN    = 8'b0010_0000,
        S_FREQ   = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } t_state;

    t_state                  r_state;
    t_state                  n_state;

    logic                    r_counting;
    logic                    r_armed;
    logic [COUNT_W-1:0]      r_count;
    logic [PERIOD_W-1:0]     r_period;
    logic [FRAC_BITS-1:0]    r_cross;
    logic [FRAC_BITS-1:0]    r_lead;

    logic                    r_edge;
    logic [PERIOD_W-1:0]     r_in_use;
    logic                    r_upd;
    logic [PERIOD_W-1:0]     r_newp;
    logic [FREQ_OUT_W-1:0]   r_freq;
    logic                    r_inv;
    logic [PROD_A_W-1:0]     r_prod_a;
    logic [PROD_B_W-1:0]     r_prod_b;
    logic [PROD_B_W-1:0]     r_scaled;

    logic                    w_edge;
    logic [SAMPLE_WIDTH-2:0] w_pos;
    logic [SAMPLE_WIDTH-1:0] w_den;
    logic [DIV_LOW_W-1:0]    w_num;
    logic                    w_counting_n;
    logic                    w_armed_n;
    logic                    w_update;
    logic [SPAN_W-1:0]       w_span;
    logic [SCALE_PROD_W-1:0] w_scaled_prod;
    logic [PROD_A_W:0]       w_sum;
    logic [PERIOD_W-1:0]     w_sat;
    logic [TENTH_PROD_W-1:0] w_tenth_prod;
    logic [DIV_W-1:0]        w_tenth;
    t_div_req                w_div_req;
    logic                    w_div_done;
    logic [DIV_W-1:0]        w_quot;

    assign w_edge = i_mid_item[ITEM_W-1];
    assign w_pos  = i_mid_item[ITEM_W-2 -: (SAMPLE_WIDTH - 1)];
    assign w_den  = i_mid_item[SAMPLE_WIDTH-1:0];
    assign w_num  = DIV_LOW_W'(w_pos) * DIV_LOW_W'(FRAC_SCALE);

    assign w_counting_n = r_counting | r_edge;
    assign w_armed_n    = r_edge ? ~r_armed : r_armed;
    assign w_update     = w_counting_n & w_armed_n;

    // leading plus trailing fraction, 1..1999
    assign w_span = {1'b0, r_lead} + SPAN_W'(FRAC_SCALE) - {1'b0, r_cross};

    // fraction term / 1000 by reciprocal
    assign w_scaled_prod = SCALE_PROD_W'(r_prod_b) * SCALE_PROD_W'(RECIP_1000);

    assign w_sum  = {1'b0, r_prod_a} + (PROD_A_W + 1)'(r_scaled);
    assign w_sat  = (|w_sum[PROD_A_W:PERIOD_W]) ? '1 : w_sum[PERIOD_W-1:0];

    // new period / 10 by reciprocal
    assign w_tenth_prod = TENTH_PROD_W'(r_newp) * TENTH_PROD_W'(RECIP_10);
    assign w_tenth      = DIV_W'(w_tenth_prod >> RECIP_10_SHIFT);

    mft_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_comb begin
        n_state    = r_state;
        w_div_req  = '0;
        o_mid_pop  = 1'b0;
        o_res_push = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_mid_empty) begin
                    o_mid_pop = 1'b1;
                    if (w_edge) begin
                        // quotient is below 1000, so ten steps suffice
                        w_div_req.start = 1'b1;
                        w_div_req.rem   = w_num[DIV_LOW_W-1:FRAC_BITS];
                        w_div_req.low   = {w_num[FRAC_BITS-1:0],
                                           {(DIV_LOW_W - FRAC_BITS){1'b0}}};
                        w_div_req.den   = DIV_W'(w_den);
                        w_div_req.steps = STEP_W'(FRAC_BITS);
                        n_state         = S_FRAC;
                    end else begin
                        n_state = S_DECIDE;
                    end
                end
            end
            S_FRAC: begin
                if (w_div_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = w_update ? S_MUL : S_OUT;
            end
            S_MUL: begin
                n_state = S_SCALE;
            end
            S_SCALE: begin
                n_state = S_TEN;
            end
            S_TEN: begin
                if (w_tenth == '0) begin
                    n_state = S_OUT;
                end else begin
                    // 1e9 / (16 * q) taken as (1e9 / 16) / q
                    w_div_req.start = 1'b1;
                    w_div_req.low   = {FREQ_NUM_DIV16,
                                       {(DIV_LOW_W - FREQ_BITS){1'b0}}};
                    w_div_req.den   = w_tenth;
                    w_div_req.steps = STEP_W'(FREQ_BITS);
                    n_state         = S_FREQ;
                end
            end
            S_FREQ: begin
                if (w_div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_counting <= 1'b0;
            r_armed    <= 1'b1;
            r_count    <= '0;
            r_period   <= PERIOD_RESET;
            r_cross    <= '0;
            r_lead     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FRAC && w_div_done) begin
                r_cross <= w_quot[FRAC_BITS-1:0];
            end
            if (r_state == S_DECIDE) begin
                r_counting <= w_counting_n;
                r_armed    <= w_update ? 1'b0 : w_armed_n;
                if (w_counting_n) begin
                    r_lead  <= r_cross;
                    r_count <= w_update ? COUNT_W'(1) : r_count + 1'b1;
                end
            end
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end else if (r_state == S_SCALE) begin
                r_period <= w_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && !i_mid_empty) begin
            r_edge   <= w_edge;
            r_in_use <= r_period;
            r_upd    <= 1'b0;
            r_newp   <= '0;
            r_freq   <= '0;
            r_inv    <= 1'b0;
        end
        if (r_state == S_DECIDE && w_update) begin
            r_upd    <= 1'b1;
            r_prod_a <= PROD_A_W'(r_period[PERIOD_W-1:4]) * PROD_A_W'(r_count);
            r_prod_b <= PROD_B_W'(w_span) * PROD_B_W'(r_period[PERIOD_W-1:16]);
        end
        if (r_state == S_MUL) begin
            r_scaled <= PROD_B_W'(w_scaled_prod >> RECIP_1000_SHIFT);
        end
        if (r_state == S_SCALE) begin
            r_newp <= w_sat;
        end
        if (r_state == S_TEN && w_tenth == '0) begin
            r_inv <= 1'b1;
        end
        if (r_state == S_FREQ && w_div_done) begin
            r_freq <= w_quot[FREQ_OUT_W-1:0];
        end
    end

    always_comb begin
        o_res_data.rising_edge    = r_edge;
        o_res_data.period_in_use  = r_in_use;
        o_res_data.period_updated = r_upd;
        o_res_data.new_period     = r_newp;
        o_res_data.freq_times10   = r_freq;
        o_res_data.freq_invalid   = r_inv;
    end

endmodule

// File: hdl/mft_checker.sv
// ----------------------------------------------------------------------------
// mft_checker
// port-level checks on the result stream of the tracker
// ----------------------------------------------------------------------------
`include "mains_frequency_tracker_assert.svh"

module mft_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               empty,
    input logic               pop,
    input logic               o_rising_edge,
    input logic [31:0]        o_period_in_use,
    input logic               o_period_updated,
    input logic [31:0]        o_new_period,
    input logic [29:0]        o_freq_times10,
    input logic               o_freq_invalid
);

    // a period update only comes with a crossing
    `MFT_ASSERT_SAME(a_update_on_edge, i_clk, i_rst_n, !empty, (!o_period_updated || o_rising_edge), "period update without a rising crossing")

    // the invalid flag tracks a new period below ten
    `MFT_ASSERT_SAME(a_invalid_small, i_clk, i_rst_n, (!empty && o_period_updated), (o_freq_invalid == (o_new_period < 32'd10)), "freq_invalid disagrees with new_period")

    // without an update the computed fields stay clear
    `MFT_ASSERT_SAME(a_quiet_fields, i_clk, i_rst_n, (!empty && !o_period_updated), ((o_new_period == 32'd0) && (o_freq_times10 == 30'd0) && !o_freq_invalid), "computed fields set without an update")

    // a stalled result holds
    `MFT_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, (!empty && !pop), (!empty && $stable(o_new_period) && $stable(o_period_in_use)), "result changed while stalled")

endmodule

bind mains_frequency_tracker mft_checker u_checker (.*);
